// File: sv/nqpc_pkg.sv
// Shared constants and factorial table for the n-queens permutation checker.
package nqpc_pkg;

    localparam int IDX_W      = 45;   // permutation rank width
    localparam int IN_TDATA_W = 48;   // rank padded to whole bytes
    localparam int OUT_TDATA_W = 8;   // two flags padded to one byte
    localparam int CFG_W      = 5;    // board size register width
    localparam int FACT_W     = 64;
    localparam int FACT_IDX_W = 5;
    localparam int FACT_N     = 21;   // 0! through 20!

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd8;

    // output word bit positions
    localparam int OUT_SOL_BIT = 0;
    localparam int OUT_ERR_BIT = 1;

    localparam logic [FACT_W-1:0] FACT [FACT_N] = '{
        64'd1,
        64'd1,
        64'd2,
        64'd6,
        64'd24,
        64'd120,
        64'd720,
        64'd5040,
        64'd40320,
        64'd362880,
        64'd3628800,
        64'd39916800,
        64'd479001600,
        64'd6227020800,
        64'd87178291200,
        64'd1307674368000,
        64'd20922789888000,
        64'd355687428096000,
        64'd6402373705728000,
        64'd121645100408832000,
        64'd2432902008176640000
    };

endpackage

// File: sv/nqueens_permutation_check.sv
// N-queens permutation checker: rank to Lehmer code to placement, then diagonal test.
//
// Input stream (s_axis): one word carries a permutation rank. The word is taken
// only while the block is idle; o_s_axis_tready is low for the whole run.
// Output stream (m_axis): one word per input, bit 0 = solution, bit 1 = rank
// out of range (n! or more). A finished word sits in an output register, so a
// new rank is taken while the previous answer still waits for the receiver.
// If the receiver stalls and the output register is full, the sequencer holds
// its answer and stays busy until the register frees.
// Config: i_cfg_we writes the board size n (saturates at MAX_BOARD), reset 8.
// Write it only while the block is idle.
// Steps: one shared compare/subtract unit is stepped by the sequencer.
//   accept, range test, digit extraction by repeated subtraction, code-to-placement,
//   pairwise diagonal scan, output handoff. Out-of-range ranks and n <= 1 go from
//   the range test straight to the output handoff.
// Reset: synchronous, active low; clears the sequencer and output valid and
// sets the board size back to 8.
module nqueens_permutation_check import nqpc_pkg::*; #(
    parameter int MAX_BOARD = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // [44:0] permutation_index
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // [0] is_solution, [1] index_error
);

    localparam int RW = $clog2(MAX_BOARD);
    localparam int NW = $clog2(MAX_BOARD + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RANGE,
        S_DEC,
        S_PLOAD,
        S_PSTEP,
        S_CLOAD,
        S_CSTEP,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [CFG_W-1:0]   r_size;
    logic [NW-1:0]      r_n;
    logic [RW-1:0]      r_nm1;
    logic [IDX_W-1:0]   r_rem;
    logic [RW-1:0]      r_dig;
    logic [RW-1:0]      r_a;
    logic [RW-1:0]      r_b;
    logic [RW-1:0]      r_cur;
    logic [RW-1:0]      r_ca;
    logic               r_ok;
    logic               r_err;
    logic               r_oval;
    logic               r_osol;
    logic               r_oerr;
    logic [RW-1:0]      r_digit [MAX_BOARD];
    logic [RW-1:0]      r_col   [MAX_BOARD];

    logic [NW-1:0]      w_size_sat;
    logic [FACT_W-1:0]  w_rem_ext;
    logic [FACT_W-1:0]  w_fact_n;
    logic [FACT_W-1:0]  w_fact_f;
    logic               w_rem_ge_f;
    logic [RW-1:0]      w_dig_rd;
    logic [RW-1:0]      w_col_rd;
    logic [RW-1:0]      w_cur_inc;
    logic [RW-1:0]      w_diff;
    logic [RW-1:0]      w_rdist;
    logic               w_accept;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - 2)'(0), r_oerr, r_osol};

    always_comb begin
        if (r_size > CFG_W'(MAX_BOARD)) begin
            w_size_sat = NW'(MAX_BOARD);
        end else begin
            w_size_sat = NW'(r_size);
        end
    end

    // shared compare/subtract against the current factorial radix
    assign w_rem_ext  = {(FACT_W - IDX_W)'(0), r_rem};
    assign w_fact_n   = FACT[FACT_IDX_W'(r_n)];
    assign w_fact_f   = FACT[FACT_IDX_W'(RW'(r_nm1 - r_b))];
    assign w_rem_ge_f = (w_rem_ext >= w_fact_f);

    // one read port per row array
    assign w_dig_rd  = r_digit[(r_state == S_PLOAD) ? r_b : r_a];
    assign w_col_rd  = r_col[(r_state == S_CLOAD) ? r_a : r_b];
    assign w_cur_inc = r_cur + RW'(w_dig_rd <= r_cur);
    assign w_diff    = (r_ca > w_col_rd) ? RW'(r_ca - w_col_rd) : RW'(w_col_rd - r_ca);
    assign w_rdist   = RW'(r_b - r_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_size  <= CFG_RESET;
            r_oval  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            // load a finished word, else drop the one just taken
            if (r_state == S_DONE && (!r_oval || i_m_axis_tready)) begin
                r_oval <= 1'b1;
            end else if (r_oval && i_m_axis_tready) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rem   <= i_s_axis_tdata[IDX_W-1:0];
                        r_n     <= w_size_sat;
                        r_nm1   <= RW'(w_size_sat - NW'(1));
                        r_state <= S_RANGE;
                    end
                end
                S_RANGE: begin
                    r_b   <= '0;
                    r_dig <= '0;
                    if (w_rem_ext >= w_fact_n) begin
                        r_ok    <= 1'b0;
                        r_err   <= 1'b1;
                        r_state <= S_DONE;
                    end else if (r_n <= NW'(1)) begin
                        // empty or single-queen board always fits
                        r_ok    <= 1'b1;
                        r_err   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (w_rem_ge_f) begin
                        r_rem <= r_rem - w_fact_f[IDX_W-1:0];
                        r_dig <= r_dig + RW'(1);
                    end else begin
                        r_digit[r_b] <= r_dig;
                        r_col[r_b]   <= r_dig;
                        r_dig        <= '0;
                        if (r_b == r_nm1) begin
                            r_state <= S_PLOAD;
                        end else begin
                            r_b <= r_b + RW'(1);
                        end
                    end
                end
                S_PLOAD: begin
                    r_cur   <= w_dig_rd;
                    r_a     <= r_b - RW'(1);
                    r_state <= S_PSTEP;
                end
                S_PSTEP: begin
                    if (r_a == '0) begin
                        r_col[r_b] <= w_cur_inc;
                        if (r_b == RW'(1)) begin
                            r_a     <= '0;
                            r_state <= S_CLOAD;
                        end else begin
                            r_b     <= r_b - RW'(1);
                            r_state <= S_PLOAD;
                        end
                    end else begin
                        r_cur <= w_cur_inc;
                        r_a   <= r_a - RW'(1);
                    end
                end
                S_CLOAD: begin
                    r_ca    <= w_col_rd;
                    r_b     <= r_a + RW'(1);
                    r_state <= S_CSTEP;
                end
                S_CSTEP: begin
                    if (w_diff == w_rdist) begin
                        r_ok    <= 1'b0;
                        r_err   <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_b == r_nm1) begin
                        if (RW'(r_a + RW'(1)) == r_nm1) begin
                            r_ok    <= 1'b1;
                            r_err   <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_a     <= r_a + RW'(1);
                            r_state <= S_CLOAD;
                        end
                    end else begin
                        r_b <= r_b + RW'(1);
                    end
                end
                S_DONE: begin
                    // hand off once the output register is free or draining
                    if (!r_oval || i_m_axis_tready) begin
                        r_osol  <= r_ok;
                        r_oerr  <= r_err;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
